// ----- sv/ucb_pkg.sv -----
// ============================================================================
// ucb_pkg: shared types and constants for the UCB child selector
// Word layouts, sequencer states and fixed-point constants.
// ============================================================================
`default_nettype none
package ucb_pkg;
	localparam int MaxChildren = 256;
	localparam int CntW = $clog2(MaxChildren);
	localparam logic [15:0] Ln2Q16 = 16'd45426;
	localparam logic [15:0] ExploreRst = 16'd256;

	typedef struct packed {
		logic        operation;
		logic signed [31:0] score;
		logic [23:0] visits;
		logic [23:0] parent_visits;
		logic        my_turn;
		logic        last;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  chosen_index;
		logic signed [31:0] chosen_value;
		logic        chose_unvisited;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_MEAN, ST_LOG_NORM, ST_LOG_SQ, ST_LOG_SQ2, ST_LN_MUL,
		ST_DIV_Q, ST_SQRT, ST_BIAS, ST_RATE, ST_OUT
	} state_t;

	// divider request from sequencer to divider
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [47:0] num;
		logic [23:0] den;
	} div_req_t;
endpackage
`default_nettype wire

// ----- sv/ucb_child_selector_core.sv -----
// ============================================================================
// ucb_child_selector_core: UCB1 child selection over a stream of children
// Rates each child (mean +/- exploration bias, or mean) and keeps the best.
// ============================================================================
// channel | dir | handshake              | word
// in      | in  | in_valid / in_stall    | ucb_pkg::in_word_t
// out     | out | out_valid / out_stall  | ucb_pkg::out_word_t
// cfg     | in  | explore_weight_we      | 16-bit C, Q8.8
// Select mode with bias runs two divisions, 16 squaring steps of the shared
// 32x32 multiplier and a square-root loop. Best-move mode and select mode with
// parent visits below two skip the log squaring, square root and bias. An
// unvisited or skipped child goes straight to the output state.
// in_stall is high from acceptance until the word is finished and any result
// has left the output register. Reset clears the running best and C to 1.0.
`default_nettype none
module ucb_child_selector_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ucb_pkg::in_word_t   in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ucb_pkg::out_word_t       out_word,
	input  wire logic                explore_weight_we,
	input  wire logic [15:0]         explore_weight_wdata
);
	import ucb_pkg::*;

	state_t state_q, state_d;
	in_word_t item_q;
	logic [15:0] c_q;
	logic signed [31:0] best_value_q;
	logic [7:0] best_index_q;
	logic [CntW-1:0] child_count_q;
	logic have_best_q, unv_q;
	logic signed [33:0] mean_q;
	logic [31:0] x_q;      // mantissa Q2.30
	logic [4:0] k_q;       // log2 integer part
	logic [15:0] frac_q;
	logic [3:0] step_q;    // fraction bit counter
	logic [47:0] acc_q;    // exploration bias holding reg (from the multiplier)
	logic [63:0] prod_s1;  // shared multiplier output
	logic [47:0] rad_q, res_q, bit_q;
	logic signed [33:0] rating;
	logic signed [31:0] rating_sat;
	logic take;
	div_req_t dreq;
	logic dbusy;
	logic [47:0] dquot;
	logic [31:0] mul_a, mul_b;
	logic [47:0] rb;
	logic [4:0] pv_msb;

	ucb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dquot));

	assign in_stall = (state_q != ST_IDLE) || out_valid;

	// shared multiplier operand select
	always_comb begin
		mul_a = x_q;
		mul_b = x_q;
		if (state_q == ST_LN_MUL) begin
			mul_a = {11'd0, k_q, frac_q};
			mul_b = {16'd0, Ln2Q16};
		end else if (state_q == ST_BIAS) begin
			mul_a = res_q[31:0];
			mul_b = {16'd0, c_q};
		end
	end

	// divider requests
	always_comb begin
		dreq = '0;
		if (state_q == ST_IDLE && in_valid && !in_stall && in_word.visits != 24'd0
			&& !unv_q) begin
			dreq.start = 1'b1;
			dreq.neg = in_word.score[31];
			dreq.num = {16'd0, in_word.score[31] ? 32'd0 - in_word.score : in_word.score};
			dreq.den = in_word.visits;
		end else if (state_q == ST_LN_MUL && step_q == 4'd1) begin
			dreq.start = 1'b1;
			dreq.num = {16'd0, prod_s1[47:16]};
			dreq.den = item_q.visits;
		end
	end

	// top set bit of parent visits (integer part of log2)
	always_comb begin
		pv_msb = '0;
		for (int i = 1; i < 24; i++)
			if (item_q.parent_visits[i]) pv_msb = 5'(i);
	end

	// rating and compare
	always_comb begin
		rating = mean_q;
		if (item_q.operation == 1'b0) begin
			rating = item_q.my_turn ? mean_q + $signed({1'b0, acc_q[32:0]})
				: mean_q - $signed({1'b0, acc_q[32:0]});
		end
		if (rating > 34'sd2147483647) rating_sat = 32'sh7FFFFFFF;
		else if (rating < -34'sd2147483648) rating_sat = 32'sh80000000;
		else rating_sat = rating[31:0];
		if (!have_best_q) take = 1'b1;
		else if (item_q.operation == 1'b0 && !item_q.my_turn)
			take = rating_sat < best_value_q;
		else take = rating_sat > best_value_q;
	end

	assign rb = res_q | bit_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid && !in_stall) begin
				if (unv_q || (in_word.visits == 24'd0)) state_d = ST_OUT;
				else state_d = ST_DIV_MEAN;
			end
			ST_DIV_MEAN: if (!dbusy) state_d = (item_q.operation == 1'b0) ? ST_LOG_NORM
				: ST_RATE;
			ST_LOG_NORM: state_d = (item_q.parent_visits < 24'd2) ? ST_RATE : ST_LOG_SQ;
			ST_LOG_SQ: state_d = ST_LOG_SQ2;
			ST_LOG_SQ2: state_d = (step_q == 4'd0) ? ST_LN_MUL : ST_LOG_SQ;
			ST_LN_MUL: if (step_q == 4'd1) state_d = ST_DIV_Q;
			ST_DIV_Q: if (!dbusy) state_d = ST_SQRT;
			ST_SQRT: if (bit_q == 48'd0) state_d = ST_BIAS;
			ST_BIAS: if (step_q == 4'd1) state_d = ST_RATE;
			ST_RATE: state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) prod_s1 <= mul_a * mul_b;

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				item_q <= in_word;
				step_q <= '0;
			end
			ST_DIV_MEAN: if (!dbusy) begin
				mean_q <= $signed({dquot[47], dquot[47], dquot[31:0]});
				acc_q <= '0;
			end
			ST_LOG_NORM: begin
				k_q <= pv_msb;
				frac_q <= '0;
				step_q <= 4'd15;
				x_q <= 32'({8'd0, item_q.parent_visits} << (5'd30 - pv_msb));
			end
			ST_LOG_SQ: ;
			ST_LOG_SQ2: begin
				if (prod_s1[63:30] >= 34'h80000000) begin
					x_q <= prod_s1[62:31];
					frac_q[step_q] <= 1'b1;
				end else x_q <= prod_s1[61:30];
				if (step_q != 4'd0) step_q <= step_q - 4'd1;
				else step_q <= 4'd2;
			end
			ST_LN_MUL: step_q <= step_q - 4'd1;
			ST_DIV_Q: if (!dbusy) begin
				rad_q <= {dquot[31:0], 16'd0};
				res_q <= '0;
				bit_q <= 48'h4000_0000_0000;
			end
			ST_SQRT: begin
				// exit cycle (bit exhausted) leaves the root untouched
				if (bit_q != 48'd0) begin
					if (bit_q > rad_q && res_q == 48'd0) bit_q <= bit_q >> 2;
					else begin
						if (rad_q >= rb) begin
							rad_q <= rad_q - rb;
							res_q <= (res_q >> 1) + bit_q;
						end else res_q <= res_q >> 1;
						bit_q <= bit_q >> 2;
					end
				end
				step_q <= 4'd2;
			end
			ST_BIAS: begin
				step_q <= step_q - 4'd1;
				acc_q <= {7'd0, prod_s1[47:7]};
			end
			ST_RATE: ;
			ST_OUT: ;
			default: ;
		endcase
	end

	// running best, result and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= ExploreRst;
			best_value_q <= '0;
			best_index_q <= '0;
			child_count_q <= '0;
			have_best_q <= 1'b0;
			unv_q <= 1'b0;
			out_valid <= 1'b0;
			out_word <= '0;
		end else begin
			if (explore_weight_we) c_q <= explore_weight_wdata;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (state_q == ST_IDLE && in_valid && !in_stall && !unv_q
				&& in_word.visits == 24'd0 && in_word.operation == 1'b0) begin
				unv_q <= 1'b1;
				have_best_q <= 1'b1;
				best_index_q <= 8'(child_count_q);
				best_value_q <= in_word.my_turn ? 32'sh7FFFFFFF : 32'sh80000000;
			end
			if (state_q == ST_RATE && take) begin
				have_best_q <= 1'b1;
				best_index_q <= 8'(child_count_q);
				best_value_q <= rating_sat;
			end
			if (state_q == ST_OUT) begin
				if (item_q.last) begin
					out_valid <= 1'b1;
					out_word.chosen_index <= have_best_q ? best_index_q : 8'd0;
					out_word.chosen_value <= have_best_q ? best_value_q : 32'sd0;
					out_word.chose_unvisited <= unv_q;
					best_value_q <= '0;
					best_index_q <= '0;
					child_count_q <= '0;
					have_best_q <= 1'b0;
					unv_q <= 1'b0;
				end else begin
					child_count_q <= child_count_q + 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/ucb_div.sv -----
// ============================================================================
// ucb_div: restoring divider, one quotient bit per cycle
// Unsigned 48 / 24 bit division with optional sign on the quotient.
// ============================================================================
`default_nettype none
module ucb_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ucb_pkg::div_req_t req,
	output logic                  busy,
	output logic [47:0]           quot
);
	import ucb_pkg::*;
	logic [47:0] num_q;
	logic [24:0] rem_q;
	logic [23:0] den_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        run_q;
	logic [24:0] trial;
	logic [24:0] shifted;

	assign shifted = {rem_q[23:0], num_q[47]};
	assign trial = shifted - {1'b0, den_q};
	assign busy = run_q;
	assign quot = neg_q ? (48'd0 - num_q) : num_q;

	// one bit per cycle; quotient bits shift into num_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			cnt_q <= 6'd47;
		end else if (run_q) begin
			if (cnt_q == 6'd0) run_q <= 1'b0;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			neg_q <= req.neg;
			rem_q <= '0;
		end else if (run_q) begin
			if (!trial[24]) begin
				rem_q <= trial;
				num_q <= {num_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[46:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/ucb_checker.sv -----
// ============================================================================
// ucb_checker: port-level checks for the child selector
// Watches handshakes and result sanity.
// ============================================================================
`default_nettype none
module ucb_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire ucb_pkg::out_word_t out_word
);
	import ucb_pkg::*;
	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");
	// a pending result blocks input
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open with result pending");
	// accepted input closes the port next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("no busy after accept");
	// unvisited result carries an extreme value
	a_unv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.chose_unvisited |->
		(out_word.chosen_value == 32'sh7FFFFFFF || out_word.chosen_value == 32'sh80000000))
		else $error("unvisited value not saturated");
endmodule

bind ucb_child_selector_core ucb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
`default_nettype wire
